### src/utt_pkg.sv
// Shared types, constants and UTF-8 encoding helpers for the UTF-16 to UTF-8 transcoder.
// No dependencies; every other file of the block imports this package.
package utt_pkg;

	localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

	localparam int CP_W = 21;
	localparam logic [CP_W-1:0] SUPPL_BASE     = 21'h10000;
	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CP_W-1:0] LIMIT_ONE_BYTE = 21'h000080;
	localparam logic [CP_W-1:0] LIMIT_TWO_BYTE = 21'h000800;

	// Queue between the front and the back end.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Index of the last byte of the replacement character, which is three bytes long.
	localparam logic [1:0] REPL_LAST_IDX = 2'd2;

	// One classified unit: an optional U+FFFD for a dropped high surrogate,
	// then an optional main code point.
	typedef struct packed {
		logic            pre_fffd;
		logic            main_valid;
		logic [CP_W-1:0] cp;
		logic            last;
	} job_t;

	// Index of the last byte of the UTF-8 form of a code point (length minus one).
	function automatic logic [1:0] enc_last_idx(input logic [CP_W-1:0] cp);
		logic [1:0] r;
		if (cp < LIMIT_ONE_BYTE) begin
			r = 2'd0;
		end else if (cp < LIMIT_TWO_BYTE) begin
			r = 2'd1;
		end else if (cp < SUPPL_BASE) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	// Byte number idx of the UTF-8 form of cp, whose last byte index is last_idx.
	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [1:0] last_idx, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (last_idx)
			2'd0: b = {1'b0, cp[6:0]};
			2'd1: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			2'd2: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

### src/utt_front.sv
// Front end: accepts UTF-16 code units, pairs surrogates and writes at most one job per unit.
// Depends on utt_pkg.
module utt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              unit_valid,
	output logic              unit_stall,
	input  logic [15:0]       code_unit,
	input  logic              final_unit,
	input  logic              q_full,
	output logic              q_push,
	output utt_pkg::job_t     q_job
);
	import utt_pkg::*;

	logic       held_valid_q;
	logic [9:0] held_bits_q;
	logic       held_valid_d;
	logic [9:0] held_bits_d;
	logic       is_high;
	logic       is_low;
	logic       accept;
	job_t       job;

	assign is_high = (code_unit >= HIGH_SURR_FIRST) && (code_unit <= HIGH_SURR_LAST);
	assign is_low  = (code_unit >= LOW_SURR_FIRST) && (code_unit <= LOW_SURR_LAST);
	assign accept  = unit_valid && !q_full;

	always_comb begin
		job.pre_fffd   = 1'b0;
		job.main_valid = 1'b1;
		job.cp         = {5'b0, code_unit};
		job.last       = final_unit;
		held_valid_d   = 1'b0;
		held_bits_d    = 10'd0;
		if (held_valid_q && is_low) begin
			// The pair {high, low} is ten plus ten bits above the supplementary base.
			job.cp = CP_W'({held_bits_q, code_unit[9:0]}) + SUPPL_BASE;
		end else begin
			job.pre_fffd = held_valid_q;
			if (is_high) begin
				if (final_unit) begin
					job.cp = REPLACEMENT_CP;
				end else begin
					job.main_valid = 1'b0;
					held_valid_d   = 1'b1;
					held_bits_d    = code_unit[9:0];
				end
			end else if (is_low) begin
				job.cp = REPLACEMENT_CP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= 10'd0;
		end else if (accept) begin
			held_valid_q <= held_valid_d;
			held_bits_q  <= held_bits_d;
		end
	end

	assign unit_stall = q_full;
	assign q_push     = accept && (job.pre_fffd || job.main_valid);
	assign q_job      = job;

endmodule

### src/utt_fifo.sv
// Short job queue that decouples the front end from the byte serializer.
// Depends on utt_pkg.
module utt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output utt_pkg::job_t head_job
);
	import utt_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("job pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("job popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond its depth");

endmodule

### src/utt_back.sv
// Back end: takes jobs from the queue and sends their UTF-8 bytes one beat per cycle while byte_stall is low.
// Depends on utt_pkg.
module utt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  utt_pkg::job_t q_job,
	output logic          q_pop,
	output logic          byte_valid,
	input  logic          byte_stall,
	output logic [7:0]    out_byte,
	output logic          run_end,
	output logic          string_end
);
	import utt_pkg::*;

	job_t            job_q;
	logic            busy_q;
	logic            phase_pre_q;
	logic [1:0]      idx_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            run_end_q;
	logic            string_end_q;
	logic [CP_W-1:0] cur_cp;
	logic [1:0]      cur_last;
	logic            advance;
	logic            step_done;
	logic            job_done;
	logic            load;

	assign cur_cp    = phase_pre_q ? REPLACEMENT_CP : job_q.cp;
	assign cur_last  = phase_pre_q ? REPL_LAST_IDX : enc_last_idx(job_q.cp);
	// The output register is free when it is empty or its beat leaves this cycle.
	assign advance   = busy_q && (!out_valid_q || !byte_stall);
	assign step_done = (idx_q == cur_last);
	assign job_done  = step_done && (!phase_pre_q || !job_q.main_valid);
	assign load      = q_valid && (!busy_q || (advance && job_done));
	assign q_pop     = load;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
		if (advance) begin
			out_byte_q   <= utf8_byte(cur_cp, cur_last, idx_q);
			run_end_q    <= job_done;
			string_end_q <= job_done && job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_pre_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= 1'b1;
				phase_pre_q <= q_job.pre_fffd;
				idx_q       <= 2'd0;
			end else if (advance && job_done) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				if (step_done) begin
					phase_pre_q <= 1'b0;
					idx_q       <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign byte_valid = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	assert property (@(posedge clk) disable iff (!arst_n) (advance && !job_done) |=> busy_q)
		else $error("serializer went idle in the middle of a job");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> idx_q <= cur_last)
		else $error("byte index ran past the end of its code point");
	assert property (@(posedge clk) disable iff (!arst_n)
			(busy_q && !phase_pre_q) |-> job_q.main_valid)
		else $error("main phase entered for a job without a code point");
	assert property (@(posedge clk) disable iff (!arst_n) string_end_q && out_valid_q |-> run_end_q)
		else $error("string end marked on a byte that does not end its run");

endmodule

### src/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level.
// Input channel: unit_valid / unit_stall with code_unit and final_unit, one
// UTF-16 code unit per beat; final_unit marks the last unit of a string.
// Output channel: byte_valid / byte_stall with out_byte, run_end and
// string_end, one UTF-8 byte per beat. run_end marks the last byte caused by
// an input unit, string_end the last byte of the whole string.
// A high surrogate produces no bytes until the next unit arrives; unpaired
// surrogates come out as U+FFFD (EF BF BD).
// The first byte of a unit passes through the job queue, the job register
// of the serializer and its output register. Throughput is set by the byte
// serializer: one byte per cycle while byte_stall is low; a unit gives up to
// four bytes (up to six when a dropped high surrogate adds a replacement character).
// A two-entry job queue lets the input take new units while the serializer
// is busy; unit_stall rises only when that queue is full.
// When byte_stall is high the current byte holds on the outputs and the
// serializer waits; the queue then fills and stalls the input.
// Reset (arst_n low) empties the queue, drops any held high surrogate and
// clears byte_valid; no bytes are lost from accepted units after reset.
// Depends on utt_pkg, utt_front, utt_fifo and utt_back.
module utf16_to_utf8_transcoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        string_end
);
	import utt_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	job_t push_job;
	job_t head_job;

	utt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	utt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	utt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_job      (head_job),
		.q_pop      (q_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for utf16_to_utf8_transcoder_unit: directed and random UTF-16 strings
// are checked byte by byte against an in-bench encoder model. Depends on utt_pkg.
module tb;
	import utt_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] value;
		logic       run_end;
		logic       string_end;
	} utf8_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        unit_valid = 1'b0;
	logic        unit_stall;
	logic [15:0] code_unit = 16'h0000;
	logic        final_unit = 1'b0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        run_end;
	logic        string_end;

	utf8_beat_t  pending_beats[$];
	logic        held_high_seen = 1'b0;
	logic [9:0]  held_high_ten = 10'd0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	bit          idling_on = 1'b1;

	utf16_to_utf8_transcoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_utf8_byte(input logic [7:0] value);
		utf8_beat_t b;
		b.value = value;
		b.run_end = 1'b0;
		b.string_end = 1'b0;
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	function automatic void encode_code_point(input logic [CP_W-1:0] cp);
		if (cp < LIMIT_ONE_BYTE) begin
			push_utf8_byte(cp[7:0]);
		end else if (cp < LIMIT_TWO_BYTE) begin
			push_utf8_byte(8'hC0 | 8'(cp >> 6));
			push_utf8_byte(8'h80 | 8'(cp & 21'h3F));
		end else if (cp < SUPPL_BASE) begin
			push_utf8_byte(8'hE0 | 8'(cp >> 12));
			push_utf8_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			push_utf8_byte(8'h80 | 8'(cp & 21'h3F));
		end else begin
			push_utf8_byte(8'hF0 | 8'((cp >> 18) & 21'h07));
			push_utf8_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
			push_utf8_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			push_utf8_byte(8'h80 | 8'(cp & 21'h3F));
		end
	endfunction

	// Appends the bytes that one accepted code unit completes.
	function automatic void predict_unit(input logic [15:0] u, input logic fin);
		int  first_new;
		bit  is_high;
		bit  is_low;
		bit  paired;
		first_new = pending_beats.size();
		is_high = (u >= HIGH_SURR_FIRST) && (u <= HIGH_SURR_LAST);
		is_low = (u >= LOW_SURR_FIRST) && (u <= LOW_SURR_LAST);
		paired = 1'b0;
		if (held_high_seen) begin
			held_high_seen = 1'b0;
			if (is_low) begin
				encode_code_point(SUPPL_BASE + CP_W'({held_high_ten, u[9:0]}));
				paired = 1'b1;
			end else begin
				encode_code_point(REPLACEMENT_CP);
			end
			held_high_ten = 10'd0;
		end
		if (!paired) begin
			if (is_high) begin
				if (fin) begin
					encode_code_point(REPLACEMENT_CP);
				end else begin
					held_high_seen = 1'b1;
					held_high_ten = u[9:0];
				end
			end else if (is_low) begin
				encode_code_point(REPLACEMENT_CP);
			end else begin
				encode_code_point(CP_W'(u));
			end
		end
		if (pending_beats.size() > first_new) begin
			pending_beats[pending_beats.size() - 1].run_end = 1'b1;
			pending_beats[pending_beats.size() - 1].string_end = fin;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_unit(input logic [15:0] u, input logic fin);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			unit_valid = 1'b0;
			code_unit = 16'($urandom);
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		unit_valid = 1'b1;
		code_unit = u;
		final_unit = fin;
		do @(posedge clk); while (unit_stall !== 1'b0);
		predict_unit(u, fin);
		@(negedge clk);
	endtask

	task automatic send_random_strings(input int unit_budget);
		logic [15:0] text[$];
		logic [19:0] scalar;
		int          sent;
		int          len;
		sent = 0;
		while (sent < unit_budget) begin
			text.delete();
			len = $urandom_range(1, 8);
			repeat (len) begin
				case ($urandom_range(0, 10))
					0, 1: text.insert(text.size(), 16'($urandom_range(16'h0000, 16'h007F)));
					2: text.insert(text.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
					3: text.insert(text.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
					4: text.insert(text.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
					5, 6, 7: begin
						scalar = 20'($urandom);
						text.insert(text.size(), HIGH_SURR_FIRST + scalar[19:10]);
						text.insert(text.size(), LOW_SURR_FIRST + scalar[9:0]);
					end
					8: text.insert(text.size(), 16'($urandom));
					9: text.insert(text.size(),
						HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)));
					default: text.insert(text.size(),
						LOW_SURR_FIRST + 16'($urandom_range(0, 1023)));
				endcase
			end
			foreach (text[i]) begin
				send_unit(text[i], i == text.size() - 1);
			end
			sent += text.size();
		end
	endtask

	task automatic test_encoding_lengths();
		logic [15:0] units[9] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
			16'hD7FF, 16'hE000, 16'hFFFD, 16'hFFFF};
		foreach (units[i]) begin
			send_unit(units[i], i == 8);
		end
	endtask

	task automatic test_surrogate_pairs();
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'hDE00, 1'b1);
	endtask

	task automatic test_unpaired_surrogates();
		send_unit(16'hDC00, 1'b0);
		// A held high followed by a plain character gives the replacement, then the character.
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		// Two highs in a row: the first is replaced, the second pairs with the low.
		send_unit(16'hD801, 1'b0);
		send_unit(16'hD802, 1'b0);
		send_unit(16'hDC03, 1'b0);
		send_unit(16'hD805, 1'b1);
		// A held high and then a final high give two replacements in one run.
		send_unit(16'hD806, 1'b0);
		send_unit(16'hDBFF, 1'b1);
		send_unit(16'hDFFF, 1'b1);
	endtask

	task automatic test_random_strings();
		send_random_strings(140);
	endtask

	task automatic test_steady_stream();
		idling_on = 1'b0;
		send_random_strings(35);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			byte_stall = 1'b1;
			stall_left--;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			byte_stall = 1'b1;
			stall_left = $urandom_range(0, 2);
		end else begin
			byte_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		utf8_beat_t want;
		if (arst_n && byte_valid === 1'b1 && byte_stall === 1'b0) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected byte, expected none, got byte %h run %b str %b",
					$time, out_byte, run_end, string_end);
				mismatches++;
			end else begin
				want = pending_beats.pop_front();
				if (out_byte !== want.value || run_end !== want.run_end ||
						string_end !== want.string_end) begin
					$display("%0t: expected byte %h run %b str %b, got byte %h run %b str %b",
						$time, want.value, want.run_end, want.string_end,
						out_byte, run_end, string_end);
					mismatches++;
				end
			end
		end
	end

	// Ends a hung run: no beat on either channel for too long.
	always @(posedge clk) begin
		if ((unit_valid === 1'b1 && unit_stall === 1'b0) ||
				(byte_valid === 1'b1 && byte_stall === 1'b0)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_encoding_lengths();
		test_surrogate_pairs();
		test_unpaired_surrogates();
		test_random_strings();
		test_steady_stream();
		unit_valid = 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
